@@ rtl/subdomain_offset_3d_core_assert.svh @@
// assertion macros for the subdomain offset core checker
`ifndef SUBDOMAIN_OFFSET_3D_CORE_ASSERT_SVH
`define SUBDOMAIN_OFFSET_3D_CORE_ASSERT_SVH

// clocked check, masked while reset is high
`define SOD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define SOD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sod_pkg.sv @@
// shared types and constants for the subdomain offset core
package sod_pkg;

  localparam int MAX_NODES = 64;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int NODE_W    = 6;
  localparam int EXT_W     = 16;
  localparam int OFS_W     = 22;
  localparam int REG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int ENTRY_W   = 3 * EXT_W;
  localparam int PLANE_W   = 2 * REG_W;
  localparam int TOTAL_W   = 3 * REG_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODES_X = 2'd0,
    CFG_NODES_Y = 2'd1,
    CFG_NODES_Z = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_T,
    S_CHECK,
    S_DIV,
    S_MUL_Z,
    S_WALK_X,
    S_WALK_Y,
    S_WALK_Z,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_t;

endpackage

@@ rtl/sod_if.sv @@
// handshake channels of the subdomain offset core
interface sod_req_if import sod_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [NODE_W-1:0] node_index;
  logic [EXT_W-1:0]  column_extent;
  logic [EXT_W-1:0]  row_extent;
  logic [EXT_W-1:0]  slice_extent;

  modport source (output valid, command, node_index, column_extent, row_extent,
                  slice_extent, input ready);
  modport sink   (input valid, command, node_index, column_extent, row_extent,
                  slice_extent, output ready);
endinterface

interface sod_rsp_if import sod_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OFS_W-1:0] offset_x;
  logic [OFS_W-1:0] offset_y;
  logic [OFS_W-1:0] offset_z;
  logic             grid_error;

  modport source (output valid, offset_x, offset_y, offset_z, grid_error, input ready);
  modport sink   (input valid, offset_x, offset_y, offset_z, grid_error, output ready);
endinterface

interface sod_cfg_if import sod_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/sod_ram.sv @@
// generic one-write one-read ram with registered read data
module sod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/subdomain_offset_3d_core.sv @@
// subdomain offset core: extent table and sequenced offset query
//
// usage
//   cfg : write beats set nodes_x (index 0), nodes_y (1), nodes_z (2); always ready,
//         indexes past the list are dropped. write only while the core is idle.
//   req : command load (0) stores the three extents of node_index and
//         gives no result; command query (1) returns one rsp beat with the node's
//         global x/y/z offsets, or grid_error with zero offsets.
//   rsp : one beat per query, held in an output register until taken.
// sequencing
//   loads are taken back to back while the core is idle.
//   a query with a bad grid or node goes from the check step straight to its result.
//   a good query runs a 6-step restoring divider twice, a shared small multiplier
//   three times, and one table read per preceding node on each axis on the
//   single ram read port. req is not ready until the query is done.
// reset
//   synchronous, active high: grid counts go to 1, every table entry reads as zero
//   through per-entry valid bits (no clearing pass), no rsp pending.
// stall
//   a held rsp does not block loads; a finished query waits in its last step
//   until the output register is free.
module subdomain_offset_3d_core import sod_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  sod_req_if.sink   req,
  sod_rsp_if.source rsp,
  sod_cfg_if.sink   cfg
);

  state_t state, state_next;

  // grid registers
  logic [REG_W-1:0] nodes_x;
  logic [REG_W-1:0] nodes_y;
  logic [REG_W-1:0] nodes_z;

  // query working registers
  logic [NODE_W-1:0]  node;
  logic [PLANE_W-1:0] plane;
  logic [TOTAL_W-1:0] total;
  logic [ADDR_W-1:0]  czp;
  logic [NODE_W-1:0]  cx, cy, cz;
  logic               err;

  // shared multiplier
  logic [PLANE_W-1:0] mul_a;
  logic [REG_W-1:0]   mul_b;
  logic [TOTAL_W-1:0] mul_p;

  // restoring divider, one quotient bit per cycle
  logic [NODE_W-1:0] dvd;
  logic [REG_W-1:0]  rem;
  logic [NODE_W-1:0] quo;
  logic [2:0]        bitcnt;
  logic              div_second;
  logic [REG_W-1:0]  div_d;
  logic [REG_W:0]    div_trial;
  logic              div_ge;
  logic [REG_W:0]    div_diff;
  logic [REG_W-1:0]  rem_next;
  logic [NODE_W-1:0] quo_next;
  logic              div_last;

  // table walk
  logic [ADDR_W-1:0] addr;
  logic [NODE_W-1:0] cnt;
  logic              pend;
  axis_t             pend_axis;
  logic              pend_vld;
  logic [MAX_NODES-1:0] ent_vld;
  logic [OFS_W-1:0]  sum_x, sum_y, sum_z;
  logic              walk_done;

  // table ports
  logic               tbl_we;
  logic [ADDR_W-1:0]  tbl_waddr;
  logic [ENTRY_W-1:0] tbl_wdata;
  logic [ENTRY_W-1:0] tbl_rdata;
  logic               rd_issue;

  // output register
  logic               rsp_valid;
  logic [OFS_W-1:0]   rsp_x, rsp_y, rsp_z;
  logic               rsp_err;
  logic               rsp_load;

  logic req_beat;
  logic load_hit;

  assign req.ready = (state == S_IDLE);
  assign req_beat  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid      = rsp_valid;
  assign rsp.offset_x   = rsp_x;
  assign rsp.offset_y   = rsp_y;
  assign rsp.offset_z   = rsp_z;
  assign rsp.grid_error = rsp_err;

  // loads go straight into the table while idle
  assign load_hit  = 32'(req.node_index) < MAX_NODES;
  assign tbl_we    = req_beat && (req.command == CMD_LOAD) && load_hit;
  assign tbl_waddr = ADDR_W'(req.node_index);
  assign tbl_wdata = {req.column_extent, req.row_extent, req.slice_extent};

  sod_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_NODES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (addr),
    .rdata (tbl_rdata)
  );

  // multiplier operand select: plane, total, then cz * plane
  always_comb begin
    mul_a = plane;
    mul_b = nodes_z;
    case (state)
      S_MUL_P: begin
        mul_a = PLANE_W'(nodes_x);
        mul_b = nodes_y;
      end
      S_MUL_Z: begin
        mul_a = plane;
        mul_b = REG_W'(cz);
      end
      default: begin
        mul_a = plane;
        mul_b = nodes_z;
      end
    endcase
  end
  // full-width product so an oversized grid never wraps into a small total
  assign mul_p = TOTAL_W'(mul_a) * TOTAL_W'(mul_b);

  // divider step
  assign div_d     = div_second ? nodes_y : nodes_x;
  assign div_trial = {rem, dvd[NODE_W-1]};
  assign div_ge    = div_trial >= {1'b0, div_d};
  assign div_diff  = div_trial - {1'b0, div_d};
  assign rem_next  = div_ge ? div_diff[REG_W-1:0] : div_trial[REG_W-1:0];
  assign quo_next  = {quo[NODE_W-2:0], div_ge};
  assign div_last  = (bitcnt == 3'(NODE_W - 1));

  // walk control per axis
  always_comb begin
    case (state)
      S_WALK_X: walk_done = (cnt == cx);
      S_WALK_Y: walk_done = (cnt == cy);
      S_WALK_Z: walk_done = (cnt == cz);
      default:  walk_done = 1'b1;
    endcase
  end
  assign rd_issue = !walk_done;

  // grid validity, checked once per query
  logic grid_bad;
  assign grid_bad = (nodes_x == '0) || (nodes_y == '0) || (nodes_z == '0) ||
                    (TOTAL_W'(node) >= total) || (32'(total) > MAX_NODES);

  assign rsp_load = (state == S_FIN) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (req_beat && (req.command == CMD_QUERY)) state_next = S_MUL_P;
      S_MUL_P:  state_next = S_MUL_T;
      S_MUL_T:  state_next = S_CHECK;
      S_CHECK:  state_next = grid_bad ? S_FIN : S_DIV;
      S_DIV:    if (div_last && div_second) state_next = S_MUL_Z;
      S_MUL_Z:  state_next = S_WALK_X;
      S_WALK_X: if (walk_done) state_next = S_WALK_Y;
      S_WALK_Y: if (walk_done) state_next = S_WALK_Z;
      S_WALK_Z: if (walk_done) state_next = S_FIN;
      S_FIN:    if (rsp_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_x <= REG_W'(1);
      nodes_y <= REG_W'(1);
      nodes_z <= REG_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_NODES_X: nodes_x <= cfg.data;
        CFG_NODES_Y: nodes_y <= cfg.data;
        CFG_NODES_Z: nodes_z <= cfg.data;
        default:     ;
      endcase
    end
  end

  // per-entry valid bits stand in for clearing the table
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (tbl_we) begin
      ent_vld[tbl_waddr] <= 1'b1;
    end
  end

  // read tracking, lines up with the registered ram output
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= rd_issue;
    end
  end

  always_ff @(posedge clk) begin
    pend_vld <= ent_vld[addr];
    case (state)
      S_WALK_Y: pend_axis <= AX_Y;
      S_WALK_Z: pend_axis <= AX_Z;
      default:  pend_axis <= AX_X;
    endcase
  end

  // query datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        node  <= req.node_index;
        sum_x <= '0;
        sum_y <= '0;
        sum_z <= '0;
      end
      S_MUL_P: plane <= mul_p[PLANE_W-1:0];
      S_MUL_T: total <= mul_p;
      S_CHECK: begin
        err        <= grid_bad;
        dvd        <= node;
        rem        <= '0;
        quo        <= '0;
        bitcnt     <= '0;
        div_second <= 1'b0;
      end
      S_DIV: begin
        if (div_last) begin
          rem    <= '0;
          quo    <= '0;
          bitcnt <= '0;
          if (!div_second) begin
            cx         <= rem_next[NODE_W-1:0];
            dvd        <= quo_next;
            div_second <= 1'b1;
          end else begin
            cy <= rem_next[NODE_W-1:0];
            cz <= quo_next;
          end
        end else begin
          rem    <= rem_next;
          quo    <= quo_next;
          dvd    <= {dvd[NODE_W-2:0], 1'b0};
          bitcnt <= bitcnt + 3'd1;
        end
      end
      S_MUL_Z: begin
        czp  <= mul_p[ADDR_W-1:0];
        addr <= ADDR_W'(node) - ADDR_W'(cx);
        cnt  <= '0;
      end
      S_WALK_X: begin
        if (walk_done) begin
          addr <= czp + ADDR_W'(cx);
          cnt  <= '0;
        end else begin
          addr <= addr + ADDR_W'(1);
          cnt  <= cnt + NODE_W'(1);
        end
      end
      S_WALK_Y: begin
        if (walk_done) begin
          addr <= ADDR_W'(node) - czp;
          cnt  <= '0;
        end else begin
          addr <= addr + nodes_x[ADDR_W-1:0];
          cnt  <= cnt + NODE_W'(1);
        end
      end
      S_WALK_Z: begin
        if (!walk_done) begin
          addr <= addr + plane[ADDR_W-1:0];
          cnt  <= cnt + NODE_W'(1);
        end
      end
      default: ;
    endcase

    // accumulate the entry read in the previous cycle
    if (pend && pend_vld) begin
      case (pend_axis)
        AX_X:    sum_x <= sum_x + OFS_W'(tbl_rdata[3*EXT_W-1:2*EXT_W]);
        AX_Y:    sum_y <= sum_y + OFS_W'(tbl_rdata[2*EXT_W-1:EXT_W]);
        default: sum_z <= sum_z + OFS_W'(tbl_rdata[EXT_W-1:0]);
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_x   <= err ? '0 : sum_x;
      rsp_y   <= err ? '0 : sum_y;
      rsp_z   <= err ? '0 : sum_z;
      rsp_err <= err;
    end
  end

endmodule

@@ rtl/sod_checker.sv @@
// port-level checker for the subdomain offset core, with its bind
`include "subdomain_offset_3d_core_assert.svh"

module sod_checker import sod_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             req_command,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [OFS_W-1:0] rsp_offset_x,
  input logic [OFS_W-1:0] rsp_offset_y,
  input logic [OFS_W-1:0] rsp_offset_z,
  input logic             rsp_grid_error
);

  // a query beat makes the core busy
  `SOD_ASSERT(a_query_busy, req_valid && req_ready && req_command == CMD_QUERY |=> !req_ready, "req ready right after a query beat")

  // an error result carries zero offsets
  `SOD_ASSERT(a_err_zero, rsp_valid && rsp_grid_error |-> rsp_offset_x == '0 && rsp_offset_y == '0 && rsp_offset_z == '0, "grid error with nonzero offsets")

  // no result pending out of reset
  `SOD_ASSERT_RST(a_rst_idle, rst |=> !rsp_valid, "rsp valid after reset")

  // a stalled result holds
  `SOD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_offset_x) && $stable(rsp_grid_error), "stalled rsp beat changed")

endmodule

bind subdomain_offset_3d_core sod_checker u_sod_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_command    (req.command),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_offset_x   (rsp.offset_x),
  .rsp_offset_y   (rsp.offset_y),
  .rsp_offset_z   (rsp.offset_z),
  .rsp_grid_error (rsp.grid_error)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the subdomain offset core: extent loads, offset queries, grid errors
module tb_top;
  import sod_pkg::*;

  // no beat on any channel for this many cycles means the core is hung
  localparam int STALL_LIMIT   = 4000;
  // settle wait after the last owed result, meant to cover a core still busy
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS  = 1400;

  typedef struct packed {
    logic [OFS_W-1:0] ofs_x;
    logic [OFS_W-1:0] ofs_y;
    logic [OFS_W-1:0] ofs_z;
    logic             grid_err;
  } offset_rsp_t;

  logic clk = 1'b0;
  logic rst;

  sod_req_if req ();
  sod_rsp_if rsp ();
  sod_cfg_if cfg ();

  subdomain_offset_3d_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the extent table and grid registers
  logic [EXT_W-1:0] col_ext [MAX_NODES];
  logic [EXT_W-1:0] row_ext [MAX_NODES];
  logic [EXT_W-1:0] slc_ext [MAX_NODES];
  logic [REG_W-1:0] grid_x, grid_y, grid_z;

  // offsets still owed by the core, oldest first
  offset_rsp_t pending_offsets [$];

  int fail_count  = 0;
  int idle_cycles = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;

  // offset the core should return for a query of this node
  function automatic offset_rsp_t predict_offset(logic [NODE_W-1:0] node);
    offset_rsp_t res;
    int unsigned nx, ny, nz, total, plane, cx, cy, cz;
    nx = 32'(grid_x);
    ny = 32'(grid_y);
    nz = 32'(grid_z);
    total = nx * ny * nz;
    res = '0;
    // zero count, node past the grid, or grid past the table: error, offsets zero
    if (nx == 0 || ny == 0 || nz == 0 || 32'(node) >= total || total > MAX_NODES) begin
      res.grid_err = 1'b1;
      return res;
    end
    plane = nx * ny;
    cx = 32'(node) % nx;
    cy = (32'(node) / nx) % ny;
    cz = 32'(node) / plane;
    // each sum wraps at 22 bits by the width of the field
    for (int unsigned i = 0; i < cx; i++)
      res.ofs_x += OFS_W'(col_ext[ADDR_W'(cz * plane + cy * nx + i)]);
    for (int unsigned i = 0; i < cy; i++)
      res.ofs_y += OFS_W'(row_ext[ADDR_W'(cz * plane + i * nx + cx)]);
    for (int unsigned i = 0; i < cz; i++)
      res.ofs_z += OFS_W'(slc_ext[ADDR_W'(i * plane + cy * nx + cx)]);
    return res;
  endfunction

  function automatic int unsigned grid_nodes();
    return 32'(grid_x) * 32'(grid_y) * 32'(grid_z);
  endfunction

  // extent value by phase flavor: 0 plain random, 1 mostly saturated, 2 corner values
  function automatic logic [EXT_W-1:0] pick_extent(int flavor);
    logic [EXT_W-1:0] v;
    v = EXT_W'($urandom_range(0, 65535));
    case (flavor)
      1: if ($urandom_range(0, 4) != 0) v = '1;
      2: case ($urandom_range(0, 3))
           0: v = '0;
           1: v = '1;
           2: v = 16'd1;
           default: ;
         endcase
      default: ;
    endcase
    return v;
  endfunction

  // node index, mostly inside the current grid when the grid is usable
  function automatic logic [NODE_W-1:0] pick_node();
    int unsigned total;
    total = grid_nodes();
    if (total >= 1 && total <= MAX_NODES && $urandom_range(0, 9) != 0)
      return NODE_W'($urandom_range(0, total - 1));
    return NODE_W'($urandom_range(0, MAX_NODES - 1));
  endfunction

  // drive one req beat, with burst/gap idling, and update the shadow state on acceptance
  task automatic issue_cmd(logic command, logic [NODE_W-1:0] node,
                           logic [EXT_W-1:0] col, logic [EXT_W-1:0] row,
                           logic [EXT_W-1:0] slc);
    int gap;
    if (gaps_on && burst_left == 0) begin
      // mostly short gaps, now and then a long one
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 5);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    req.valid         <= 1'b1;
    req.command       <= command;
    req.node_index    <= node;
    req.column_extent <= col;
    req.row_extent    <= row;
    req.slice_extent  <= slc;
    do @(posedge clk); while (!req.ready);
    if (burst_left > 0) burst_left--;
    items_sent++;
    if (command == CMD_QUERY) begin
      pending_offsets.push_back(predict_offset(node));
    end else begin
      // node_index is 6 bits, so every load lands inside the table
      col_ext[node] = col;
      row_ext[node] = row;
      slc_ext[node] = slc;
    end
  endtask

  task automatic load_node(logic [NODE_W-1:0] node, logic [EXT_W-1:0] col,
                           logic [EXT_W-1:0] row, logic [EXT_W-1:0] slc);
    issue_cmd(CMD_LOAD, node, col, row, slc);
  endtask

  // extents ride along on queries with random values; the core must ignore them
  task automatic query_node(logic [NODE_W-1:0] node);
    issue_cmd(CMD_QUERY, node, pick_extent(0), pick_extent(0), pick_extent(0));
  endtask

  // drop valid, wait out every owed result, then let any trailing work finish
  task automatic wait_core_idle();
    req.valid <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg valid stays high across back-to-back writes
  task automatic write_reg(cfg_idx_t idx, logic [REG_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      CFG_NODES_X: grid_x = val;
      CFG_NODES_Y: grid_y = val;
      CFG_NODES_Z: grid_z = val;
      default: ;
    endcase
  endtask

  // only called with the core idle
  task automatic set_grid(logic [REG_W-1:0] nx, logic [REG_W-1:0] ny, logic [REG_W-1:0] nz);
    write_reg(CFG_NODES_X, nx);
    write_reg(CFG_NODES_Y, ny);
    write_reg(CFG_NODES_Z, nz);
    cfg.valid <= 1'b0;
  endtask

  // grid counts come up as 1x1x1: node 0 is good with zero offsets, nodes 1 and 63 are errors
  task automatic test_reset_state();
    query_node(6'd0);
    query_node(6'd1);
    query_node(6'd63);
    load_node(6'd0, '1, '1, '1);
    query_node(6'd0);
  endtask

  // zero counts, register values past 64, and grids larger than the table
  task automatic test_bad_grids();
    wait_core_idle();
    set_grid(7'd0, 7'd1, 7'd1);
    query_node(6'd0);
    wait_core_idle();
    set_grid(7'd1, 7'd0, 7'd1);
    query_node(6'd0);
    wait_core_idle();
    set_grid(7'd1, 7'd1, 7'd0);
    query_node(6'd0);
    wait_core_idle();
    set_grid(7'd127, 7'd127, 7'd127);
    query_node(6'd0);
    wait_core_idle();
    set_grid(7'd65, 7'd1, 7'd1);
    query_node(6'd0);
    wait_core_idle();
    set_grid(7'd4, 7'd4, 7'd5);
    query_node(6'd10);
  endtask

  // a full 64-node axis in each direction, with saturated extents on the walk path
  task automatic test_full_axes();
    wait_core_idle();
    set_grid(7'd64, 7'd1, 7'd1);
    load_node(6'd62, '1, '1, '1);
    load_node(6'd31, '1, 16'd0, '1);
    query_node(6'd63);
    query_node(6'd0);
    wait_core_idle();
    set_grid(7'd1, 7'd64, 7'd1);
    query_node(6'd63);
    wait_core_idle();
    set_grid(7'd1, 7'd1, 7'd64);
    query_node(6'd63);
    wait_core_idle();
    set_grid(7'd4, 7'd4, 7'd4);
    query_node(6'd63);
    query_node(6'd21);
  endtask

  // random grids; most good grids are first filled in order, then loads and queries mix
  task automatic test_random_grids();
    int sel, flavor, rot, mix_items;
    int unsigned nx, ny, nz, total, tmp;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_core_idle();
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        nx = $urandom_range(1, 64);
        ny = $urandom_range(1, 64 / nx);
        nz = $urandom_range(1, 64 / (nx * ny));
      end else if (sel < 80) begin
        // one axis at full length
        nx = 64;
        ny = 1;
        nz = 1;
      end else if (sel < 90) begin
        nx = $urandom_range(0, 64);
        ny = $urandom_range(0, 64);
        nz = 0;
      end else begin
        nx = $urandom_range(0, 127);
        ny = $urandom_range(0, 127);
        nz = $urandom_range(0, 127);
      end
      // rotate so each axis gets the large and the zero counts
      rot = $urandom_range(0, 2);
      repeat (rot) begin
        tmp = nx;
        nx  = ny;
        ny  = nz;
        nz  = tmp;
      end
      set_grid(nx[REG_W-1:0], ny[REG_W-1:0], nz[REG_W-1:0]);
      flavor  = $urandom_range(0, 2);
      gaps_on = ($urandom_range(0, 3) != 0);
      total   = grid_nodes();
      if (total >= 1 && total <= MAX_NODES && $urandom_range(0, 4) != 0) begin
        for (int unsigned n = 0; n < total; n++)
          load_node(n[NODE_W-1:0], pick_extent(flavor), pick_extent(flavor),
                    pick_extent(flavor));
      end
      mix_items = $urandom_range(30, 80);
      repeat (mix_items) begin
        if ($urandom_range(0, 1) == 0)
          load_node(pick_node(), pick_extent(flavor), pick_extent(flavor),
                    pick_extent(flavor));
        else
          query_node(pick_node());
      end
    end
    gaps_on = 1'b1;
  endtask

  // result check and receiver stall pattern
  int stall_mode = 0;
  int mode_left  = 0;
  int cyc_count  = 0;

  always @(posedge clk) begin : rsp_check
    offset_rsp_t want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_offsets.size() == 0) begin
          $error("result beat with no query outstanding");
          fail_count++;
        end else begin
          want = pending_offsets.pop_front();
          if (rsp.offset_x !== want.ofs_x) begin
            $error("offset_x: expected %0d, actual %0d", want.ofs_x, rsp.offset_x);
            fail_count++;
          end
          if (rsp.offset_y !== want.ofs_y) begin
            $error("offset_y: expected %0d, actual %0d", want.ofs_y, rsp.offset_y);
            fail_count++;
          end
          if (rsp.offset_z !== want.ofs_z) begin
            $error("offset_z: expected %0d, actual %0d", want.ofs_z, rsp.offset_z);
            fail_count++;
          end
          if (rsp.grid_error !== want.grid_err) begin
            $error("grid_error: expected %0d, actual %0d", want.grid_err, rsp.grid_error);
            fail_count++;
          end
        end
      end
      // stall modes: always ready, light stalls, heavy stalls, rare ready pulses
      cyc_count++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 160);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= ($urandom_range(0, 3) != 0);
        2: rsp.ready <= ($urandom_range(0, 3) == 0);
        default: rsp.ready <= (cyc_count % 24 == 0);
      endcase
    end
  end

  // hang detection: count cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst               <= 1'b1;
    req.valid         <= 1'b0;
    req.command       <= CMD_LOAD;
    req.node_index    <= '0;
    req.column_extent <= '0;
    req.row_extent    <= '0;
    req.slice_extent  <= '0;
    cfg.valid         <= 1'b0;
    cfg.index         <= CFG_NODES_X;
    cfg.data          <= '0;
    // shadow state matches the core after reset
    grid_x = 7'd1;
    grid_y = 7'd1;
    grid_z = 7'd1;
    for (int n = 0; n < MAX_NODES; n++) begin
      col_ext[ADDR_W'(n)] = '0;
      row_ext[ADDR_W'(n)] = '0;
      slc_ext[ADDR_W'(n)] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_bad_grids();
    test_full_axes();
    test_random_grids();
    wait_core_idle();

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sod_pkg.sv
rtl/sod_if.sv
rtl/sod_ram.sv
rtl/subdomain_offset_3d_core.sv
rtl/sod_checker.sv
tb/sv/tb_top.sv
